>>> sv/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants for the KMP substring matcher
// Holds the item codes, the fixed field widths and the sequencer states.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

    // Item codes carried on the func field
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a transaction
        S_READ,   // memory read of pattern byte j and failure entry j-1
        S_CMP,    // compare / fall back / finish the step
        S_FRD,    // memory read of failure entry j after a full match
        S_FTAKE,  // take failure entry j as the new prefix
        S_EMIT    // hand the result to the output register
    } kmp_state_t;

endpackage

>>> sv/kmp_substring_matcher_unit.sv
// ----------------------------------------------------------------------------
// kmp_substring_matcher_unit: streaming Knuth-Morris-Pratt matcher
// Stores a pattern and builds its failure table byte by byte, then scans
// text bytes and reports one result transaction per text byte.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  item     | item_valid / item_stall     | func, data_byte, last_in_run
//  result   | result_valid / result_stall | match_found, match_start,
//           |                             | match_count
//  cfg      | cfg_wr_en                   | cfg_wr_data (first_only)
//
//  Steps: one shared compare step is a pattern memory read (S_READ) and a
//  compare (S_CMP). A text byte takes k+1 compare steps for k failure
//  fallbacks, then S_EMIT, plus S_FRD and S_FTAKE on a full match (failure
//  table lookup); with no pattern stored it goes straight to S_EMIT. A pattern
//  byte is taken in S_IDLE alone when first or beyond capacity, else k+1 steps.
//  item_stall is high while a byte is being worked on.
//  A finished result sits in the output register; the next item is accepted
//  while it waits. A result stalls in the sequencer only if the output
//  register is still full and result_stall is high.
//  Reset clears all control state; the pattern and failure memories are
//  not cleared since entries are only read below the stored pattern length.
//
module kmp_substring_matcher_unit
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = 64
) (
    input  logic               clk,
    input  logic               rst_n,

    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,

    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               func,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic               last_in_run,

    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic               match_found,
    output logic [COUNT_W-1:0] match_start,
    output logic [COUNT_W-1:0] match_count
);

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    // pattern and failure memories, single write / single registered read
    logic [BYTE_W-1:0] store_mem [MAX_PATTERN];
    logic [IDX_W-1:0]  fail_mem  [MAX_PATTERN];
    logic [BYTE_W-1:0] store_rd_reg;
    logic [IDX_W-1:0]  fail_rd_reg;
    logic [IDX_W-1:0]  fail_raddr;

    logic              store_we;
    logic [IDX_W-1:0]  store_waddr;
    logic              fail_we;
    logic [IDX_W-1:0]  fail_waddr;
    logic [IDX_W-1:0]  fail_wdata;

    // control state
    kmp_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              open_reg, open_next;
    logic [IDX_W-1:0]  bp_reg, bp_next;
    logic [IDX_W-1:0]  prefix_reg, prefix_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0] tally_reg, tally_next;
    logic              fr_reg, fr_next;
    logic              first_only_reg, first_only_next;
    logic              result_valid_reg, result_valid_next;

    // current item and working prefix
    logic              func_reg, func_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              found_reg, found_next;
    logic [COUNT_W-1:0] start_reg, start_next;

    // output payload
    logic              match_found_reg;
    logic [COUNT_W-1:0] match_start_reg;
    logic [COUNT_W-1:0] match_count_reg;
    logic              res_load;

    // combinational helpers
    logic              item_take;
    logic [LEN_W-1:0]  len_eff;
    logic [IDX_W-1:0]  bp_eff;
    logic              byte_eq;
    logic              full_hit;
    logic [COUNT_W-1:0] j_wide;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign match_found  = match_found_reg;
    assign match_start  = match_start_reg;
    assign match_count  = match_count_reg;

    assign fail_raddr = (state_reg == S_FRD) ? j_reg : IDX_W'(j_reg - IDX_W'(1));
    assign byte_eq    = (store_rd_reg == byte_reg);
    assign j_wide     = COUNT_W'(j_reg);

    always_comb
    begin
        state_next        = state_reg;
        len_next          = len_reg;
        open_next         = open_reg;
        bp_next           = bp_reg;
        prefix_next       = prefix_reg;
        pos_next          = pos_reg;
        tally_next        = tally_reg;
        fr_next           = fr_reg;
        first_only_next   = cfg_wr_en ? cfg_wr_data : first_only_reg;
        result_valid_next = result_valid_reg && result_stall;
        func_next         = func_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        j_next            = j_reg;
        found_next        = found_reg;
        start_next        = start_reg;
        store_we          = 1'b0;
        store_waddr       = '0;
        fail_we           = 1'b0;
        fail_waddr        = '0;
        fail_wdata        = '0;
        res_load          = 1'b0;
        len_eff           = open_reg ? len_reg : '0;
        bp_eff            = open_reg ? bp_reg : '0;
        full_hit          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    func_next = func;
                    byte_next = data_byte;
                    last_next = last_in_run;
                    if (func == FUNC_PATTERN)
                    begin
                        // a pattern byte ends any text run
                        prefix_next = '0;
                        pos_next    = '0;
                        tally_next  = '0;
                        fr_next     = 1'b0;
                        open_next   = 1'b1;
                        len_next    = len_eff;
                        bp_next     = bp_eff;
                        if (len_eff < LEN_MAX)
                        begin
                            store_we    = 1'b1;
                            store_waddr = len_eff[IDX_W-1:0];
                            if (len_eff == '0)
                            begin
                                fail_we    = 1'b1;
                                fail_waddr = '0;
                                fail_wdata = '0;
                                bp_next    = '0;
                                len_next   = LEN_W'(1);
                                if (last_in_run)
                                    open_next = 1'b0;
                            end
                            else
                            begin
                                j_next     = (LEN_W'(bp_eff) >= len_eff) ? '0 : bp_eff;
                                state_next = S_READ;
                            end
                        end
                        else if (last_in_run)
                        begin
                            open_next = 1'b0;
                        end
                    end
                    else
                    begin
                        found_next = 1'b0;
                        start_next = '0;
                        if (len_reg == '0)
                        begin
                            j_next     = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            j_next     = (LEN_W'(prefix_reg) >= len_reg) ? '0 : prefix_reg;
                            state_next = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if ((j_reg != '0) && !byte_eq)
                begin
                    // fall back along the failure chain
                    j_next     = fail_rd_reg;
                    state_next = S_READ;
                end
                else if (func_reg == FUNC_PATTERN)
                begin
                    j_next     = byte_eq ? IDX_W'(j_reg + IDX_W'(1)) : j_reg;
                    fail_we    = 1'b1;
                    fail_waddr = len_reg[IDX_W-1:0];
                    fail_wdata = j_next;
                    bp_next    = j_next;
                    len_next   = LEN_W'(len_reg + LEN_W'(1));
                    if (last_reg)
                        open_next = 1'b0;
                    state_next = S_IDLE;
                end
                else if (byte_eq && (LEN_W'(j_reg) == LEN_W'(len_reg - LEN_W'(1))))
                begin
                    // whole pattern matched at this byte
                    full_hit = !(first_only_reg && fr_reg);
                    if (full_hit)
                    begin
                        found_next = 1'b1;
                        start_next = (pos_reg >= j_wide) ? (pos_reg - j_wide) : '0;
                        if (tally_reg != COUNT_SAT)
                            tally_next = tally_reg + COUNT_W'(1);
                        fr_next = 1'b1;
                    end
                    state_next = S_FRD;
                end
                else
                begin
                    j_next     = byte_eq ? IDX_W'(j_reg + IDX_W'(1)) : j_reg;
                    state_next = S_EMIT;
                end
            end

            S_FRD:
            begin
                state_next = S_FTAKE;
            end

            S_FTAKE:
            begin
                j_next     = fail_rd_reg;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    res_load          = 1'b1;
                    result_valid_next = 1'b1;
                    prefix_next       = j_reg;
                    if (pos_reg != COUNT_SAT)
                        pos_next = pos_reg + COUNT_W'(1);
                    if (last_reg)
                    begin
                        prefix_next = '0;
                        pos_next    = '0;
                        tally_next  = '0;
                        fr_next     = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            len_reg          <= '0;
            open_reg         <= 1'b0;
            bp_reg           <= '0;
            prefix_reg       <= '0;
            pos_reg          <= '0;
            tally_reg        <= '0;
            fr_reg           <= 1'b0;
            first_only_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            open_reg         <= open_next;
            bp_reg           <= bp_next;
            prefix_reg       <= prefix_next;
            pos_reg          <= pos_next;
            tally_reg        <= tally_next;
            fr_reg           <= fr_next;
            first_only_reg   <= first_only_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        j_reg     <= j_next;
        found_reg <= found_next;
        start_reg <= start_next;
        if (res_load)
        begin
            match_found_reg <= found_reg;
            match_start_reg <= start_reg;
            match_count_reg <= tally_reg;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= byte_next;
        if (fail_we)
            fail_mem[fail_waddr] <= fail_wdata;
        store_rd_reg <= store_mem[j_reg];
        fail_rd_reg  <= fail_mem[fail_raddr];
    end

endmodule

>>> sv/kmp_checker.sv
// ----------------------------------------------------------------------------
// kmp_checker: port-level checks for the KMP substring matcher
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module kmp_checker
    import kmp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               func,
    input logic               result_valid,
    input logic               result_stall,
    input logic               match_found,
    input logic [COUNT_W-1:0] match_start,
    input logic [COUNT_W-1:0] match_count
);

    // stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(match_found) && $stable(match_start)
            && $stable(match_count))
        else $error("result changed while stalled");

    // a text byte taken from the item channel leaves the sequencer busy
    a_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (func == FUNC_TEXT) |=> item_stall)
        else $error("text byte did not stall the item channel");

    // a new result only appears out of a busy sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result appeared without work in progress");

    // a reported match is counted
    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && match_found |-> (match_count != '0))
        else $error("match reported with zero count");

endmodule

bind kmp_substring_matcher_unit kmp_checker u_kmp_checker (.*);
